### rtl/core/imm_pkg.sv
`timescale 1ns / 1ps

package imm_pkg;

    // sizing
    localparam int MAX_DIM     = 8;
    localparam int ELEM_WIDTH  = 32;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int ROW_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A = 2'd0,
        REG_COLS_A = 2'd1,
        REG_ROWS_B = 2'd2,
        REG_COLS_B = 2'd3
    } t_cfg_reg;

    // work handed from the front to the back
    typedef enum logic {
        CMD_ERROR    = 1'b0,
        CMD_MULTIPLY = 1'b1
    } t_cmd;

    // clamped matrix dimensions
    typedef struct packed {
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] ca;
        logic [DIM_W-1:0] rb;
        logic [DIM_W-1:0] cb;
    } t_dims;

    // element store write
    typedef struct packed {
        logic              a_we;
        logic              b_we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_store_wr;

    // one result transaction
    typedef struct packed {
        logic [DATA_W-1:0] product;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  column;
        logic              last;
        logic              error;
    } t_result;

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // sign extend from the element width
    function automatic logic [DATA_W-1:0] sext_elem(input logic [DATA_W-1:0] raw);
        logic signed [DATA_W-1:0] s;
        s = $signed(raw << (DATA_W - ELEM_WIDTH));
        s = s >>> (DATA_W - ELEM_WIDTH);
        return s;
    endfunction

endpackage

### rtl/core/integer_matrix_multiply.sv
// Loading: one element per cycle while full is low; full rises for the compute phase once
// both matrices are in. Compute: each product element takes one store read per inner step,
// then the multiply and accumulate drain; full stays high from the last element until the
// final product is pushed into the result queue, which waits while that queue is full.
// Inner dimension mismatch: one error transaction per input, one per cycle unless stalled.
// Reset (synchronous, active low): all dimensions read 1, load counts and queues empty.
`timescale 1ns / 1ps

module integer_matrix_multiply (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [imm_pkg::DIM_W-1:0]               i_cfg_data,
    input  logic                                    push,
    output logic                                    full,
    input  logic                                    i_kind,
    input  logic [31:0]                             i_element,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [31:0]                             o_product,
    output logic [2:0]                              o_row,
    output logic [2:0]                              o_column,
    output logic                                    o_last,
    output logic                                    o_error
);

    import imm_pkg::*;

    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_cols_a;
    logic [DIM_W-1:0] r_rows_b;
    logic [DIM_W-1:0] r_cols_b;
    t_dims            w_dims;
    t_store_wr        w_wr;
    logic             w_wait;
    logic             w_cmd_push;
    t_cmd             w_cmd_in;
    logic             w_cmd_full;
    logic             w_cmd_empty;
    logic             w_cmd_pop;
    t_cmd             w_cmd_out;
    logic [ADDR_W-1:0] w_a_raddr;
    logic [ADDR_W-1:0] w_b_raddr;
    logic [DATA_W-1:0] w_a_rdata;
    logic [DATA_W-1:0] w_b_rdata;
    logic             w_res_push;
    t_result          w_res_in;
    logic             w_res_full;
    logic             w_done;
    t_result          w_res_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DIM_W'(1);
            r_cols_a <= DIM_W'(1);
            r_rows_b <= DIM_W'(1);
            r_cols_b <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_ROWS_B: r_rows_b <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_dims.ra = clamp_dim(r_rows_a);
    assign w_dims.ca = clamp_dim(r_cols_a);
    assign w_dims.rb = clamp_dim(r_rows_b);
    assign w_dims.cb = clamp_dim(r_cols_b);

    // load side
    imm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_kind    (i_kind),
        .i_element (i_element),
        .i_dims    (w_dims),
        .i_cfg_we  (i_cfg_we),
        .i_q_full  (w_cmd_full),
        .i_done    (w_done),
        .o_full    (full),
        .o_wait    (w_wait),
        .o_q_push  (w_cmd_push),
        .o_q_cmd   (w_cmd_in),
        .o_wr      (w_wr)
    );

    // element stores
    imm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_wr.a_we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    imm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_wr.b_we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // front to back commands
    imm_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_cmd_pop),
        .o_full  (w_cmd_full),
        .o_empty (w_cmd_empty),
        .o_cmd   (w_cmd_out)
    );

    // compute side
    imm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (w_dims),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .i_res_full  (w_res_full),
        .i_a_data    (w_a_rdata),
        .i_b_data    (w_b_rdata),
        .o_cmd_pop   (w_cmd_pop),
        .o_a_addr    (w_a_raddr),
        .o_b_addr    (w_b_raddr),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .o_done      (w_done)
    );

    // result queue
    imm_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .i_pop   (pop),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_res   (w_res_out)
    );

    assign o_product = w_res_out.product;
    assign o_row     = w_res_out.row;
    assign o_column  = w_res_out.column;
    assign o_last    = w_res_out.last;
    assign o_error   = w_res_out.error;

    // checks
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full queue");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_wait)
        else $error("compute finished with no load waiting");

    a_no_store_write_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wait |-> !w_wr.a_we && !w_wr.b_we)
        else $error("store written while compute reads it");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push && w_res_in.error |-> w_res_in.last && w_res_in.product == '0)
        else $error("malformed error transaction");

endmodule

### rtl/core/imm_ram.sv
`timescale 1ns / 1ps

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/imm_front.sv
`timescale 1ns / 1ps

module imm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_kind,
    input  logic [31:0]           i_element,
    input  imm_pkg::t_dims        i_dims,
    input  logic                  i_cfg_we,
    input  logic                  i_q_full,
    input  logic                  i_done,
    output logic                  o_full,
    output logic                  o_wait,
    output logic                  o_q_push,
    output imm_pkg::t_cmd         o_q_cmd,
    output imm_pkg::t_store_wr    o_wr
);

    import imm_pkg::*;

    logic [COUNT_W-1:0] r_cnt_a;
    logic [COUNT_W-1:0] r_cnt_b;
    logic [COUNT_W-1:0] n_cnt_a;
    logic [COUNT_W-1:0] n_cnt_b;
    logic               r_wait;
    logic [COUNT_W-1:0] w_size_a;
    logic [COUNT_W-1:0] w_size_b;
    logic               w_accept;
    logic               w_mismatch;
    logic               w_stored;
    logic               w_complete;

    assign o_full   = i_q_full | r_wait;
    assign o_wait   = r_wait;
    assign w_accept = i_push & ~o_full;

    // classify the incoming transaction
    always_comb begin
        w_size_a   = COUNT_W'(i_dims.ra) * COUNT_W'(i_dims.ca);
        w_size_b   = COUNT_W'(i_dims.rb) * COUNT_W'(i_dims.cb);
        w_mismatch = (i_dims.ca != i_dims.rb);
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        w_stored   = 1'b0;
        o_wr.a_we  = 1'b0;
        o_wr.b_we  = 1'b0;
        o_wr.addr  = i_kind ? r_cnt_b[ADDR_W-1:0] : r_cnt_a[ADDR_W-1:0];
        o_wr.data  = sext_elem(i_element);
        if (w_accept && !w_mismatch) begin
            if (!i_kind && r_cnt_a < w_size_a) begin
                o_wr.a_we = 1'b1;
                n_cnt_a   = r_cnt_a + COUNT_W'(1);
                w_stored  = 1'b1;
            end else if (i_kind && r_cnt_b < w_size_b) begin
                o_wr.b_we = 1'b1;
                n_cnt_b   = r_cnt_b + COUNT_W'(1);
                w_stored  = 1'b1;
            end
        end
        w_complete = w_stored && n_cnt_a >= w_size_a && n_cnt_b >= w_size_b;
        o_q_push   = w_accept && (w_mismatch || w_complete);
        o_q_cmd    = w_mismatch ? CMD_ERROR : CMD_MULTIPLY;
    end

    // load counts and hold-off while the back reads the stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_wait  <= 1'b0;
        end else begin
            if (i_cfg_we || w_complete) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
            end else begin
                r_cnt_a <= n_cnt_a;
                r_cnt_b <= n_cnt_b;
            end
            if (w_complete) begin
                r_wait <= 1'b1;
            end else if (i_done) begin
                r_wait <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/imm_cmd_q.sv
`timescale 1ns / 1ps

module imm_cmd_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  imm_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output imm_pkg::t_cmd o_cmd
);

    import imm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    // two entry command queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

### rtl/core/imm_back.sv
`timescale 1ns / 1ps

module imm_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  imm_pkg::t_dims               i_dims,
    input  logic                         i_cmd_empty,
    input  imm_pkg::t_cmd                i_cmd,
    input  logic                         i_res_full,
    input  logic [imm_pkg::DATA_W-1:0]   i_a_data,
    input  logic [imm_pkg::DATA_W-1:0]   i_b_data,
    output logic                         o_cmd_pop,
    output logic [imm_pkg::ADDR_W-1:0]   o_a_addr,
    output logic [imm_pkg::ADDR_W-1:0]   o_b_addr,
    output logic                         o_res_push,
    output imm_pkg::t_result             o_res,
    output logic                         o_done
);

    import imm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_PUSH
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_i;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_k;
    logic              r_v1;
    logic              r_v2;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              w_last_k;
    logic              w_last_i;
    logic              w_last_j;

    assign w_last_k = (r_k == IDX_W'(i_dims.ca - DIM_W'(1)));
    assign w_last_i = (r_i == IDX_W'(i_dims.ra - DIM_W'(1)));
    assign w_last_j = (r_j == IDX_W'(i_dims.cb - DIM_W'(1)));

    // store addresses for a[i][k] and b[k][j]
    assign o_a_addr = ADDR_W'(r_i) * ADDR_W'(i_dims.ca) + ADDR_W'(r_k);
    assign o_b_addr = ADDR_W'(r_k) * ADDR_W'(i_dims.cb) + ADDR_W'(r_j);

    // result and command handshakes
    always_comb begin
        o_cmd_pop      = 1'b0;
        o_res_push     = 1'b0;
        o_done         = 1'b0;
        o_res.product  = r_acc;
        o_res.row      = ROW_W'(r_i);
        o_res.column   = ROW_W'(r_j);
        o_res.last     = w_last_i & w_last_j;
        o_res.error    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd == CMD_ERROR) begin
                        o_res.product = '0;
                        o_res.row     = '0;
                        o_res.column  = '0;
                        o_res.last    = 1'b1;
                        o_res.error   = 1'b1;
                        o_res_push    = ~i_res_full;
                        o_cmd_pop     = ~i_res_full;
                    end else begin
                        o_cmd_pop = 1'b1;
                    end
                end
            end
            S_PUSH: begin
                o_res_push = ~i_res_full;
                o_done     = ~i_res_full & w_last_i & w_last_j;
            end
            default: begin
            end
        endcase
    end

    // sequencer and multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        r_prod <= i_a_data * i_b_data;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + r_prod;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty && i_cmd == CMD_MULTIPLY) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_last_k) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_res_full) begin
                        r_acc <= '0;
                        r_k   <= '0;
                        if (w_last_j) begin
                            r_j <= '0;
                            r_i <= r_i + IDX_W'(1);
                        end else begin
                            r_j <= r_j + IDX_W'(1);
                        end
                        r_state <= (w_last_i && w_last_j) ? S_IDLE : S_RUN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/imm_out_q.sv
`timescale 1ns / 1ps

module imm_out_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  imm_pkg::t_result i_res,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output imm_pkg::t_result o_res
);

    import imm_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    // four entry result queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + 3'(w_push) - 3'(w_pop);
        end
    end

endmodule

### verif/tb_integer_matrix_multiply.sv
`timescale 1ns / 1ps

module tb_integer_matrix_multiply;
    import imm_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_TARGET   = 400;

    // one element waiting to be loaded
    typedef struct packed {
        logic        kind;
        logic [31:0] value;
    } t_load;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DIM_W-1:0]     i_cfg_data;
    logic                 push;
    logic                 full;
    logic                 i_kind;
    logic [31:0]          i_element;
    logic                 empty;
    logic                 pop;
    logic [31:0]          o_product;
    logic [2:0]           o_row;
    logic [2:0]           o_column;
    logic                 o_last;
    logic                 o_error;

    // predictor state
    logic [DIM_W-1:0] dim_reg [4];
    logic [31:0]      a_mem [STORE_DEPTH];
    logic [31:0]      b_mem [STORE_DEPTH];
    int unsigned      a_fill;
    int unsigned      b_fill;

    t_load       load_queue [$];
    t_result     due_products [$];
    t_load       next_load;
    int unsigned loads_open;
    int unsigned item_total;
    int unsigned fail_count;
    int unsigned load_gap;
    int unsigned pop_gap;
    int unsigned pop_draw;
    int unsigned stall_cycles;
    bit          steady;

    integer_matrix_multiply uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_kind     (i_kind),
        .i_element  (i_element),
        .empty      (empty),
        .pop        (pop),
        .o_product  (o_product),
        .o_row      (o_row),
        .o_column   (o_column),
        .o_last     (o_last),
        .o_error    (o_error)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // dimension as the block uses it
    function automatic int unsigned used_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (v > DIM_W'(MAX_DIM)) begin
            return MAX_DIM;
        end
        return 32'(v);
    endfunction

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    // extremes, small values and full random words
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // mostly small, sometimes the maximum or out of range
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return DIM_W'(MAX_DIM);
            1: return '0;
            2: return DIM_W'($urandom_range(MAX_DIM + 1, 15));
            default: return DIM_W'($urandom_range(1, 3));
        endcase
    endfunction

    // expected products for one accepted element
    task automatic predict_products(input logic kind, input logic [31:0] value);
        int unsigned ra, ca, rb, cb;
        logic [31:0] acc;
        t_result     res;
        ra = used_dim(dim_reg[REG_ROWS_A]);
        ca = used_dim(dim_reg[REG_COLS_A]);
        rb = used_dim(dim_reg[REG_ROWS_B]);
        cb = used_dim(dim_reg[REG_COLS_B]);
        if (ca != rb) begin
            res = '0;
            res.last = 1'b1;
            res.error = 1'b1;
            due_products.push_back(res);
            return;
        end
        if (kind == 1'b0) begin
            if (a_fill >= ra * ca) return;
            a_mem[a_fill] = value;
            a_fill++;
        end else begin
            if (b_fill >= rb * cb) return;
            b_mem[b_fill] = value;
            b_fill++;
        end
        if (a_fill < ra * ca || b_fill < rb * cb) return;
        for (int i = 0; i < ra; i++) begin
            for (int j = 0; j < cb; j++) begin
                acc = '0;
                for (int k = 0; k < ca; k++) begin
                    acc = acc + a_mem[i * ca + k] * b_mem[k * cb + j];
                end
                res.product = acc;
                res.row = 3'(i);
                res.column = 3'(j);
                res.last = (i == ra - 1) && (j == cb - 1);
                res.error = 1'b0;
                due_products.push_back(res);
            end
        end
        a_fill = 0;
        b_fill = 0;
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (due_products.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected transaction, expected none, actual product %0h row %0d col %0d",
                     $time, o_product, o_row, o_column);
            return;
        end
        want = due_products.pop_front();
        compare_field("product", want.product, o_product);
        compare_field("row", 32'(want.row), 32'(o_row));
        compare_field("column", 32'(want.column), 32'(o_column));
        compare_field("last", 32'(want.last), 32'(o_last));
        compare_field("error", 32'(want.error), 32'(o_error));
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input t_cfg_reg idx, input logic [DIM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dim_reg[idx] = value;
        a_fill = 0;
        b_fill = 0;
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                            input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
    endtask

    task automatic queue_load(input logic kind, input logic [31:0] value, input bit counted);
        t_load item;
        item.kind = kind;
        item.value = value;
        load_queue.push_back(item);
        loads_open++;
        if (counted) item_total++;
    endtask

    // all loads accepted, all products seen, then let the block settle
    task automatic wait_idle();
        while (loads_open != 0 || due_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one pair of matrices, in order or interleaved, with ignored extras
    task automatic load_pair(input int unsigned sa, input int unsigned sb);
        int unsigned na, nb;
        bit          mixed;
        na = 0;
        nb = 0;
        mixed = ($urandom_range(0, 3) == 0);
        while (na < sa || nb < sb) begin
            if (na < sa && (nb == sb || !mixed || $urandom_range(0, 1) == 1)) begin
                queue_load(1'b0, pick_element(), 1'b1);
                na++;
                if (na == sa && nb < sb && $urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 2)) queue_load(1'b0, pick_element(), 1'b0);
                end
            end else begin
                queue_load(1'b1, pick_element(), 1'b1);
                nb++;
                if (nb == sb && na < sa && $urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 2)) queue_load(1'b1, pick_element(), 1'b0);
                end
            end
        end
    endtask

    task automatic random_phase();
        logic [DIM_W-1:0] d [4];
        int unsigned      sa, sb, pairs;
        for (int n = 0; n < 4; n++) d[n] = pick_dim();
        if ($urandom_range(0, 7) != 0) d[REG_ROWS_B] = d[REG_COLS_A];
        set_dims(d[REG_ROWS_A], d[REG_COLS_A], d[REG_ROWS_B], d[REG_COLS_B]);
        if (used_dim(d[REG_COLS_A]) != used_dim(d[REG_ROWS_B])) begin
            // mismatched inner dimensions, every element is an error
            repeat ($urandom_range(3, 10)) queue_load(1'($urandom_range(0, 1)), pick_element(), 1'b1);
            return;
        end
        sa = used_dim(d[REG_ROWS_A]) * used_dim(d[REG_COLS_A]);
        sb = used_dim(d[REG_ROWS_B]) * used_dim(d[REG_COLS_B]);
        pairs = (sa + sb > 20) ? 1 : $urandom_range(1, 3);
        repeat (pairs) load_pair(sa, sb);
        // partial first matrix, dropped by the next register write
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, sa)) queue_load(1'b0, pick_element(), 1'b1);
        end
    endtask

    // load driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            load_gap <= 0;
        end else begin
            if (push && !full) begin
                predict_products(i_kind, i_element);
                loads_open--;
            end
            if (!push || !full) begin
                if (load_gap != 0) begin
                    push <= 1'b0;
                    load_gap <= load_gap - 1;
                end else if (load_queue.size() != 0) begin
                    next_load = load_queue.pop_front();
                    i_kind <= next_load.kind;
                    i_element <= next_load.value;
                    push <= 1'b1;
                    load_gap <= draw_gap();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_gap <= 0;
        end else if (pop && !empty) begin
            check_result();
            pop_draw = draw_gap();
            if (pop_draw == 0) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                pop_gap <= pop_draw;
            end
        end else if (!pop) begin
            if (pop_gap != 0) begin
                pop_gap <= pop_gap - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles without a transaction while work is pending
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((push && !full) || (pop && !empty)
                     || (loads_open == 0 && due_products.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("integer_matrix_multiply regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_ROWS_A;
        i_cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        i_kind = 1'b0;
        i_element = '0;
        for (int n = 0; n < 4; n++) dim_reg[n] = DIM_W'(1);
        a_fill = 0;
        b_fill = 0;
        loads_open = 0;
        item_total = 0;
        fail_count = 0;
        steady = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single elements at the extremes, then an extra element for a full matrix
        queue_load(1'b0, 32'h7fff_ffff, 1'b1);
        queue_load(1'b1, 32'h7fff_ffff, 1'b1);
        queue_load(1'b0, 32'h8000_0000, 1'b1);
        queue_load(1'b1, 32'h8000_0000, 1'b1);
        queue_load(1'b0, 32'hffff_ffff, 1'b1);
        queue_load(1'b0, 32'h1234_5678, 1'b0);
        queue_load(1'b1, 32'h8000_0001, 1'b1);
        wait_idle();

        // inner dimensions differ
        steady = 1'b0;
        set_dims(4'd1, 4'd2, 4'd1, 4'd1);
        queue_load(1'b0, 32'h5555_aaaa, 1'b1);
        queue_load(1'b1, 32'haaaa_5555, 1'b1);
        wait_idle();

        // zero and over-range dimensions clamp to 1 x 8 times 8 x 1
        set_dims(4'd0, 4'd15, 4'd9, 4'd0);
        repeat (8) queue_load(1'b0, pick_element(), 1'b1);
        repeat (8) queue_load(1'b1, pick_element(), 1'b1);
        wait_idle();

        while (item_total < ITEM_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            random_phase();
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("integer_matrix_multiply regression: pass");
        end else begin
            $display("integer_matrix_multiply regression: fail");
        end
        $finish;
    end

endmodule
